FILE: src/mfqs_pkg.sv
`timescale 1ns / 1ps

package mfqs_pkg;

	// process table and queue geometry
	localparam int SLOT_COUNT  = 16;
	localparam int SLOT_IDX_W  = $clog2(SLOT_COUNT);
	localparam int COUNT_W     = $clog2(SLOT_COUNT + 1);
	localparam int SLOT_PORT_W = 4;
	localparam int PID_WIDTH   = 22;
	localparam int LEVELS      = 4;
	localparam int LEVEL_W     = 2;
	localparam int QUANTUM_W   = 24;
	localparam int REQ_W       = 2;
	localparam int CFG_IDX_W   = 2;

	// request codes
	localparam logic [REQ_W-1:0] REQ_ADMIT    = 2'd0;
	localparam logic [REQ_W-1:0] REQ_SCHEDULE = 2'd1;
	localparam logic [REQ_W-1:0] REQ_FINISH   = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_ONE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_TWO   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_THREE = 2'd2;

	localparam logic [QUANTUM_W-1:0] QUANTUM_ONE_RST   = 24'd10000;
	localparam logic [QUANTUM_W-1:0] QUANTUM_TWO_RST   = 24'd20000;
	localparam logic [QUANTUM_W-1:0] QUANTUM_THREE_RST = 24'd40000;

	// level names
	localparam logic [LEVEL_W-1:0] LEVEL_ZERO  = 2'd0;
	localparam logic [LEVEL_W-1:0] LEVEL_ONE   = 2'd1;
	localparam logic [LEVEL_W-1:0] LEVEL_TWO   = 2'd2;
	localparam logic [LEVEL_W-1:0] LEVEL_THREE = 2'd3;

	typedef struct packed {
		logic                 push;
		logic [LEVEL_W-1:0]   push_level;
		logic [PID_WIDTH-1:0] push_pid;
		logic                 pop;
		logic [LEVEL_W-1:0]   pop_level;
	} queue_cmd_t;

	typedef struct packed {
		logic [LEVELS-1:0] nonempty;
		logic [LEVELS-1:0] full;
	} queue_status_t;

	typedef struct packed {
		logic                  busy_we;
		logic                  busy_val;
		logic                  level_we;
		logic [LEVEL_W-1:0]    level_val;
		logic [SLOT_IDX_W-1:0] idx;
	} slot_update_t;

	typedef struct packed {
		logic                  free_found;
		logic [SLOT_IDX_W-1:0] free_idx;
		logic                  busy;
		logic [LEVEL_W-1:0]    level;
	} slot_status_t;

endpackage

FILE: src/mfqs_slot_table.sv
`timescale 1ns / 1ps

module mfqs_slot_table (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [mfqs_pkg::SLOT_IDX_W-1:0]  query_idx,
	input  mfqs_pkg::slot_update_t           upd,
	output mfqs_pkg::slot_status_t           status
);

	logic [mfqs_pkg::SLOT_COUNT-1:0] busy_q;
	logic [mfqs_pkg::LEVEL_W-1:0]    level_q [mfqs_pkg::SLOT_COUNT];

	// lowest free slot
	always_comb begin
		status.free_found = 1'b0;
		status.free_idx   = '0;
		for (int i = mfqs_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
			if (!busy_q[i]) begin
				status.free_found = 1'b1;
				status.free_idx   = mfqs_pkg::SLOT_IDX_W'(i);
			end
		end
		status.busy  = busy_q[query_idx];
		status.level = level_q[query_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
		end else if (upd.busy_we) begin
			busy_q[upd.idx] <= upd.busy_val;
		end
	end

	// level is only read for busy slots, no reset
	always_ff @(posedge clk) begin
		if (upd.level_we) begin
			level_q[upd.idx] <= upd.level_val;
		end
	end

endmodule

FILE: src/mfqs_queues.sv
`timescale 1ns / 1ps

module mfqs_queues (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mfqs_pkg::queue_cmd_t            cmd,
	output mfqs_pkg::queue_status_t         status,
	output logic [mfqs_pkg::PID_WIDTH-1:0]  rd_pid
);

	localparam int ADDR_W = mfqs_pkg::LEVEL_W + mfqs_pkg::SLOT_IDX_W;
	localparam int DEPTH  = mfqs_pkg::LEVELS * mfqs_pkg::SLOT_COUNT;

	logic [mfqs_pkg::SLOT_IDX_W-1:0] head_q  [mfqs_pkg::LEVELS];
	logic [mfqs_pkg::SLOT_IDX_W-1:0] tail_q  [mfqs_pkg::LEVELS];
	logic [mfqs_pkg::COUNT_W-1:0]    count_q [mfqs_pkg::LEVELS];
	logic [mfqs_pkg::PID_WIDTH-1:0]  store_q [DEPTH];
	logic [mfqs_pkg::PID_WIDTH-1:0]  rd_pid_q;
	logic [ADDR_W-1:0]               wr_addr;
	logic [ADDR_W-1:0]               rd_addr;

	function automatic logic [mfqs_pkg::SLOT_IDX_W-1:0] ptr_inc(
		input logic [mfqs_pkg::SLOT_IDX_W-1:0] p
	);
		logic [mfqs_pkg::SLOT_IDX_W:0] nxt;
		nxt = {1'b0, p} + 1'b1;
		if (nxt == (mfqs_pkg::SLOT_IDX_W + 1)'(mfqs_pkg::SLOT_COUNT)) begin
			return '0;
		end
		return nxt[mfqs_pkg::SLOT_IDX_W-1:0];
	endfunction

	always_comb begin
		for (int l = 0; l < mfqs_pkg::LEVELS; l++) begin
			status.nonempty[l] = (count_q[l] != '0);
			status.full[l]     = (count_q[l] ==
				mfqs_pkg::COUNT_W'(mfqs_pkg::SLOT_COUNT));
		end
	end

	assign wr_addr = {cmd.push_level, tail_q[cmd.push_level]};
	assign rd_addr = {cmd.pop_level, head_q[cmd.pop_level]};
	assign rd_pid  = rd_pid_q;

	// pointer and fill count per level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < mfqs_pkg::LEVELS; l++) begin
				head_q[l]  <= '0;
				tail_q[l]  <= '0;
				count_q[l] <= '0;
			end
		end else begin
			for (int l = 0; l < mfqs_pkg::LEVELS; l++) begin
				if (cmd.push && cmd.push_level == mfqs_pkg::LEVEL_W'(l)) begin
					tail_q[l]  <= ptr_inc(tail_q[l]);
					count_q[l] <= count_q[l] + 1'b1;
				end else if (cmd.pop && cmd.pop_level == mfqs_pkg::LEVEL_W'(l)) begin
					head_q[l]  <= ptr_inc(head_q[l]);
					count_q[l] <= count_q[l] - 1'b1;
				end
			end
		end
	end

	// pid storage, registered read on pop
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			store_q[wr_addr] <= cmd.push_pid;
		end
		if (cmd.pop) begin
			rd_pid_q <= store_q[rd_addr];
		end
	end

endmodule

FILE: src/multilevel_feedback_queue_scheduler.sv
`timescale 1ns / 1ps

// Four-level feedback scheduler. Each accepted request transaction produces
// exactly one result transaction, in order. Admit takes the lowest free
// process slot and queues the pid at level 1; schedule pops the head of the
// lowest-numbered non-empty queue; a finish report frees its slot or requeues
// the pid at level 0, level 1 (short burst) or one level down (saturating at
// level 3). Throughput is one transaction per clock unless the result channel
// stalls; a request passes through the input register and the result register
// around the single decision stage, whose queue memory read lands directly in
// the result register. A waiting result blocks the next request only once the
// input register also holds one. The quantum registers are written on
// cfg_wr_en with no handshake and must only change while the block is idle.
// No clearing pass is needed after reset: queue contents are only read
// after a push.

module multilevel_feedback_queue_scheduler (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_wr_en,
	input  logic [mfqs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mfqs_pkg::QUANTUM_W-1:0]      cfg_data,
	// request channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [mfqs_pkg::REQ_W-1:0]          req_type,
	input  logic [mfqs_pkg::SLOT_PORT_W-1:0]    slot,
	input  logic [mfqs_pkg::PID_WIDTH-1:0]      pid,
	input  logic                                completed,
	input  logic [mfqs_pkg::QUANTUM_W-1:0]      last_burst,
	// result channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                ok,
	output logic [mfqs_pkg::PID_WIDTH-1:0]      out_pid,
	output logic [mfqs_pkg::SLOT_PORT_W-1:0]    out_slot,
	output logic [mfqs_pkg::LEVEL_W-1:0]        out_level
);

	// quantum registers
	logic [mfqs_pkg::QUANTUM_W-1:0] quantum_one_q;
	logic [mfqs_pkg::QUANTUM_W-1:0] quantum_two_q;
	logic [mfqs_pkg::QUANTUM_W-1:0] quantum_three_q;

	// input register
	logic                              valid_s1;
	logic [mfqs_pkg::REQ_W-1:0]        req_s1;
	logic [mfqs_pkg::SLOT_PORT_W-1:0]  slot_s1;
	logic [mfqs_pkg::PID_WIDTH-1:0]    pid_s1;
	logic                              completed_s1;
	logic [mfqs_pkg::QUANTUM_W-1:0]    burst_s1;

	// result register
	logic                              valid_s2;
	logic                              ok_s2;
	logic                              pop_s2;
	logic [mfqs_pkg::SLOT_PORT_W-1:0]  slot_s2;
	logic [mfqs_pkg::LEVEL_W-1:0]      level_s2;

	logic                              advance;
	logic                              fire;

	mfqs_pkg::queue_cmd_t              q_cmd;
	mfqs_pkg::queue_status_t           q_stat;
	logic [mfqs_pkg::PID_WIDTH-1:0]    q_rd_pid;
	mfqs_pkg::slot_update_t            st_upd;
	mfqs_pkg::slot_status_t            st_stat;
	logic [mfqs_pkg::SLOT_IDX_W-1:0]   slot_idx;

	logic                              sched_hit;
	logic [mfqs_pkg::LEVEL_W-1:0]      sched_level;
	logic [mfqs_pkg::QUANTUM_W-1:0]    quantum_sel;
	logic [mfqs_pkg::LEVEL_W-1:0]      next_level;
	logic                              slot_valid;

	logic                              ok_n;
	logic                              pop_n;
	logic [mfqs_pkg::SLOT_PORT_W-1:0]  slot_n;
	logic [mfqs_pkg::LEVEL_W-1:0]      level_n;

	// the input register moves on whenever the result register is free
	assign advance  = !valid_s2 || out_ready;
	assign fire     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	assign slot_idx   = mfqs_pkg::SLOT_IDX_W'(slot_s1);
	assign slot_valid = (32'(slot_s1) < mfqs_pkg::SLOT_COUNT) && st_stat.busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_one_q   <= mfqs_pkg::QUANTUM_ONE_RST;
			quantum_two_q   <= mfqs_pkg::QUANTUM_TWO_RST;
			quantum_three_q <= mfqs_pkg::QUANTUM_THREE_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				mfqs_pkg::CFG_QUANTUM_ONE:   quantum_one_q   <= cfg_data;
				mfqs_pkg::CFG_QUANTUM_TWO:   quantum_two_q   <= cfg_data;
				mfqs_pkg::CFG_QUANTUM_THREE: quantum_three_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// lowest non-empty queue
	always_comb begin
		sched_hit   = 1'b0;
		sched_level = '0;
		for (int l = mfqs_pkg::LEVELS - 1; l >= 0; l--) begin
			if (q_stat.nonempty[l]) begin
				sched_hit   = 1'b1;
				sched_level = mfqs_pkg::LEVEL_W'(l);
			end
		end
	end

	// feedback: level 0 stays, short burst goes back to level 1, long burst demotes down to level 3
	always_comb begin
		unique case (st_stat.level)
			mfqs_pkg::LEVEL_ONE:   quantum_sel = quantum_one_q;
			mfqs_pkg::LEVEL_TWO:   quantum_sel = quantum_two_q;
			default:               quantum_sel = quantum_three_q;
		endcase
		if (st_stat.level == mfqs_pkg::LEVEL_ZERO) begin
			next_level = mfqs_pkg::LEVEL_ZERO;
		end else if (burst_s1 < quantum_sel) begin
			next_level = mfqs_pkg::LEVEL_ONE;
		end else if (st_stat.level == mfqs_pkg::LEVEL_THREE) begin
			next_level = mfqs_pkg::LEVEL_THREE;
		end else begin
			next_level = st_stat.level + 1'b1;
		end
	end

	// request decode
	always_comb begin
		q_cmd   = '0;
		st_upd  = '0;
		ok_n    = 1'b0;
		pop_n   = 1'b0;
		slot_n  = '0;
		level_n = '0;
		q_cmd.push_pid = pid_s1;
		if (fire) begin
			unique case (req_s1)
				mfqs_pkg::REQ_ADMIT: begin
					if (st_stat.free_found && !q_stat.full[mfqs_pkg::LEVEL_ONE]) begin
						q_cmd.push       = 1'b1;
						q_cmd.push_level = mfqs_pkg::LEVEL_ONE;
						st_upd.busy_we   = 1'b1;
						st_upd.busy_val  = 1'b1;
						st_upd.level_we  = 1'b1;
						st_upd.level_val = mfqs_pkg::LEVEL_ONE;
						st_upd.idx       = st_stat.free_idx;
						ok_n             = 1'b1;
						slot_n           = mfqs_pkg::SLOT_PORT_W'(st_stat.free_idx);
						level_n          = mfqs_pkg::LEVEL_ONE;
					end
				end
				mfqs_pkg::REQ_SCHEDULE: begin
					if (sched_hit) begin
						q_cmd.pop       = 1'b1;
						q_cmd.pop_level = sched_level;
						ok_n            = 1'b1;
						pop_n           = 1'b1;
						level_n         = sched_level;
					end
				end
				mfqs_pkg::REQ_FINISH: begin
					if (slot_valid) begin
						st_upd.idx = slot_idx;
						if (completed_s1) begin
							st_upd.busy_we  = 1'b1;
							st_upd.busy_val = 1'b0;
							ok_n            = 1'b1;
						end else begin
							// level changes even when the target queue is full
							st_upd.level_we  = 1'b1;
							st_upd.level_val = next_level;
							if (!q_stat.full[next_level]) begin
								q_cmd.push       = 1'b1;
								q_cmd.push_level = next_level;
								ok_n             = 1'b1;
								level_n          = next_level;
							end
						end
					end
				end
				default: ;
			endcase
		end
	end

	mfqs_slot_table u_slot_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.query_idx (slot_idx),
		.upd       (st_upd),
		.status    (st_stat)
	);

	mfqs_queues u_queues (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (q_cmd),
		.status (q_stat),
		.rd_pid (q_rd_pid)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1       <= req_type;
			slot_s1      <= slot;
			pid_s1       <= pid;
			completed_s1 <= completed;
			burst_s1     <= last_burst;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			ok_s2    <= ok_n;
			pop_s2   <= pop_n;
			slot_s2  <= slot_n;
			level_s2 <= level_n;
		end
	end

	assign out_valid = valid_s2;
	assign ok        = ok_s2;
	assign out_slot  = slot_s2;
	assign out_level = level_s2;
	// popped pid comes straight from the queue memory read register
	assign out_pid   = pop_s2 ? q_rd_pid : '0;

	// a pop only ever targets a queue holding entries
	assert property (@(posedge clk) disable iff (!arst_n)
		q_cmd.pop |-> q_stat.nonempty[q_cmd.pop_level])
		else $error("pop from an empty queue");

	// a push only ever targets a queue with room
	assert property (@(posedge clk) disable iff (!arst_n)
		q_cmd.push |-> !q_stat.full[q_cmd.push_level])
		else $error("push into a full queue");

	// one queue operation per transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		!(q_cmd.push && q_cmd.pop))
		else $error("push and pop in the same cycle");

	// an admitted slot is busy afterwards
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && req_s1 == mfqs_pkg::REQ_ADMIT && ok_n) |=>
		!st_stat.free_found || st_stat.free_idx != $past(st_stat.free_idx))
		else $error("admitted slot still free");

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

import mfqs_pkg::*;

// one request transaction as it goes onto the request channel
typedef struct packed {
	logic [REQ_W-1:0]       req_type;
	logic [SLOT_PORT_W-1:0] slot;
	logic [PID_WIDTH-1:0]   pid;
	logic                   completed;
	logic [QUANTUM_W-1:0]   last_burst;
} sched_req_t;

// one result transaction as it comes off the result channel
typedef struct packed {
	logic                   ok;
	logic [PID_WIDTH-1:0]   pid;
	logic [SLOT_PORT_W-1:0] slot;
	logic [LEVEL_W-1:0]     level;
} sched_result_t;

// shadow of the process table and the four level queues, plus the results still owed
class queue_state;
	logic [QUANTUM_W-1:0] quantum [LEVELS];
	bit                   slot_busy [SLOT_COUNT];
	logic [LEVEL_W-1:0]   slot_level [SLOT_COUNT];
	logic [PID_WIDTH-1:0] level_fifo [LEVELS][$];
	sched_result_t        owed_results [$];
	int                   failures;

	function new();
		quantum[LEVEL_ZERO]  = '0;
		quantum[LEVEL_ONE]   = QUANTUM_ONE_RST;
		quantum[LEVEL_TWO]   = QUANTUM_TWO_RST;
		quantum[LEVEL_THREE] = QUANTUM_THREE_RST;
		foreach (slot_busy[i]) begin
			slot_busy[i]  = 1'b0;
			slot_level[i] = LEVEL_ONE;
		end
		failures = 0;
	endfunction

	function void set_quantum(logic [CFG_IDX_W-1:0] index, logic [QUANTUM_W-1:0] value);
		case (index)
		CFG_QUANTUM_ONE: quantum[LEVEL_ONE] = value;
		CFG_QUANTUM_TWO: quantum[LEVEL_TWO] = value;
		CFG_QUANTUM_THREE: quantum[LEVEL_THREE] = value;
		default: ;
		endcase
	endfunction

	function int owed();
		return owed_results.size();
	endfunction

	// random busy slot, or -1 when the table is empty
	function int pick_busy_slot(output int busy_n);
		int busy_list [$];
		foreach (slot_busy[i])
			if (slot_busy[i])
				busy_list.push_back(i);
		busy_n = busy_list.size();
		if (busy_n == 0)
			return -1;
		return busy_list[$urandom_range(busy_n - 1)];
	endfunction

	// advance the table and queues by one accepted request, queue the owed result
	function void apply_request(sched_req_t r);
		sched_result_t res;
		int free_slot;
		bit popped;
		logic [LEVEL_W-1:0] cur;
		logic [LEVEL_W-1:0] nxt;
		res = '0;
		case (r.req_type)
		REQ_ADMIT: begin
			free_slot = -1;
			for (int i = SLOT_COUNT - 1; i >= 0; i--)
				if (!slot_busy[i])
					free_slot = i;
			// a full level one queue refuses the admit and keeps the slot free
			if (free_slot >= 0 && level_fifo[LEVEL_ONE].size() < SLOT_COUNT) begin
				level_fifo[LEVEL_ONE].push_back(r.pid);
				slot_busy[free_slot]  = 1'b1;
				slot_level[free_slot] = LEVEL_ONE;
				res.ok    = 1'b1;
				res.slot  = SLOT_PORT_W'(free_slot);
				res.level = LEVEL_ONE;
			end
		end
		REQ_SCHEDULE: begin
			popped = 1'b0;
			for (int l = 0; l < LEVELS; l++)
				if (!popped && level_fifo[l].size() != 0) begin
					res.pid   = level_fifo[l].pop_front();
					res.level = LEVEL_W'(l);
					res.ok    = 1'b1;
					popped    = 1'b1;
				end
		end
		REQ_FINISH: begin
			if (slot_busy[r.slot] && r.completed) begin
				// queued copies of the pid stay where they are
				slot_busy[r.slot] = 1'b0;
				res.ok = 1'b1;
			end else if (slot_busy[r.slot]) begin
				cur = slot_level[r.slot];
				if (cur == LEVEL_ZERO)
					nxt = LEVEL_ZERO;
				else if (r.last_burst < quantum[cur])
					nxt = LEVEL_ONE;
				else if (cur == LEVEL_THREE)
					nxt = LEVEL_THREE;
				else
					nxt = cur + 1'b1;
				// level moves even when the target queue is full and the pid is lost
				slot_level[r.slot] = nxt;
				if (level_fifo[nxt].size() < SLOT_COUNT) begin
					level_fifo[nxt].push_back(r.pid);
					res.ok    = 1'b1;
					res.level = nxt;
				end
			end
		end
		default: ;
		endcase
		owed_results.push_back(res);
	endfunction

	function void note_failure(string what, sched_result_t want, sched_result_t got);
		if (failures < 10)
			$display("%0t %s: expected ok=%0d pid=%h slot=%0d level=%0d, got ok=%0d pid=%h slot=%0d level=%0d",
				$realtime, what, want.ok, want.pid, want.slot, want.level,
				got.ok, got.pid, got.slot, got.level);
		failures++;
	endfunction

	function void compare_result(sched_result_t got);
		sched_result_t want;
		if (owed_results.size() == 0) begin
			note_failure("result with no request outstanding", '0, got);
		end else begin
			want = owed_results.pop_front();
			if (got.ok !== want.ok || got.pid !== want.pid || got.slot !== want.slot ||
					got.level !== want.level)
				note_failure("result mismatch", want, got);
		end
	endfunction
endclass

module tb_top;

	localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

	localparam int DIRECTED_ITEMS  = 22;
	localparam int NUM_PHASES      = 6;
	localparam int ITEMS_PER_PHASE = 225;
	localparam int TOTAL_ITEMS     = DIRECTED_ITEMS + NUM_PHASES * ITEMS_PER_PHASE;
	// extra idle cycles after the last owed result has come back
	localparam int DRAIN_CYCLES    = 4;
	// cycles with no transaction on either channel before the run is abandoned
	localparam int WATCHDOG_LIMIT  = 2000;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_wr_en;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [QUANTUM_W-1:0]   cfg_data;
	logic                   in_valid;
	logic                   in_ready;
	logic [REQ_W-1:0]       req_type;
	logic [SLOT_PORT_W-1:0] slot;
	logic [PID_WIDTH-1:0]   pid;
	logic                   completed;
	logic [QUANTUM_W-1:0]   last_burst;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic                   ok;
	logic [PID_WIDTH-1:0]   out_pid;
	logic [SLOT_PORT_W-1:0] out_slot;
	logic [LEVEL_W-1:0]     out_level;

	queue_state book;
	int items_sent     = 0;
	int send_idle_pct  = 27;
	int recv_stall_pct = 59;
	int quiet_cycles   = 0;

	multilevel_feedback_queue_scheduler dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.slot       (slot),
		.pid        (pid),
		.completed  (completed),
		.last_burst (last_burst),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.ok         (ok),
		.out_pid    (out_pid),
		.out_slot   (out_slot),
		.out_level  (out_level)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// result side back-pressure, rerolled every cycle
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// result check and watchdog; values read here are the ones from before the edge
	always @(posedge clk) begin : monitor
		sched_result_t seen;
		if (arst_n === 1'b1) begin
			if (out_valid && out_ready) begin
				seen = '{ok, out_pid, out_slot, out_level};
				book.compare_result(seen);
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	function automatic sched_req_t make_request(logic [REQ_W-1:0] kind,
			logic [SLOT_PORT_W-1:0] s, logic [PID_WIDTH-1:0] p, logic done,
			logic [QUANTUM_W-1:0] burst);
		return '{kind, s, p, done, burst};
	endfunction

	// present one request transaction, hold it until taken, then maybe go quiet
	task automatic issue(input sched_req_t r);
		in_valid   <= 1'b1;
		req_type   <= r.req_type;
		slot       <= r.slot;
		pid        <= r.pid;
		completed  <= r.completed;
		last_burst <= r.last_burst;
		do @(posedge clk); while (!in_ready);
		book.apply_request(r);
		items_sent++;
		// idling profile: sender light / receiver heavy, then swapped, then none
		case (items_sent * 3 / TOTAL_ITEMS)
		0: begin
			send_idle_pct  = 27;
			recv_stall_pct = 59;
		end
		1: begin
			send_idle_pct  = 59;
			recv_stall_pct = 27;
		end
		default: begin
			send_idle_pct  = 0;
			recv_stall_pct = 0;
		end
		endcase
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
	endtask

	// stop sending and let every owed result come back before touching the quanta
	task automatic drain();
		in_valid <= 1'b0;
		while (book.owed() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// back-to-back register writes, model updated alongside since the block is idle
	task automatic load_quanta(input logic [QUANTUM_W-1:0] q_one, q_two, q_three);
		logic [CFG_IDX_W-1:0] idx [3];
		logic [QUANTUM_W-1:0] val [3];
		idx = '{CFG_QUANTUM_ONE, CFG_QUANTUM_TWO, CFG_QUANTUM_THREE};
		val = '{q_one, q_two, q_three};
		for (int i = 0; i < 3; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			book.set_quantum(idx[i], val[i]);
			@(posedge clk);
		end
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		sched_req_t r;
		int pick;
		int busy_n;
		int roll;
		logic [QUANTUM_W-1:0] q_one;
		logic [QUANTUM_W-1:0] q_two;
		logic [QUANTUM_W-1:0] q_three;
		logic [QUANTUM_W-1:0] q_near;

		book = new();
		in_valid   <= 1'b0;
		cfg_wr_en  <= 1'b0;
		cfg_index  <= CFG_QUANTUM_ONE;
		cfg_data   <= '0;
		req_type   <= REQ_ADMIT;
		slot       <= '0;
		pid        <= '0;
		completed  <= 1'b0;
		last_burst <= '0;
		arst_n     <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, reset quanta 10000 / 20000 / 40000
		// nothing queued yet: schedule comes back empty
		issue(make_request(REQ_SCHEDULE, '0, '0, 1'b0, '0));
		// report on a slot that was never admitted, every field at its top
		issue(make_request(REQ_FINISH, '1, '1, 1'b1, '1));
		// unknown request code is answered and ignored
		issue(make_request(REQ_UNKNOWN, '1, '1, 1'b1, '1));
		// two admits land in slots 0 and 1 at level one
		issue(make_request(REQ_ADMIT, '0, '0, 1'b0, '0));
		issue(make_request(REQ_ADMIT, '0, '1, 1'b0, '0));
		// just under the level one quantum: back to level one
		issue(make_request(REQ_FINISH, 4'd0, '0, 1'b0, 24'd9999));
		// exactly the quantum demotes, then again to the bottom level
		issue(make_request(REQ_FINISH, 4'd1, '1, 1'b0, 24'd10000));
		issue(make_request(REQ_FINISH, 4'd1, '1, 1'b0, '1));
		// bottom level saturates, then a short burst lifts it to level one
		issue(make_request(REQ_FINISH, 4'd1, '1, 1'b0, 24'd40000));
		issue(make_request(REQ_FINISH, 4'd1, '1, 1'b0, 24'd39999));
		// completion frees the slot but leaves its queued pids behind
		issue(make_request(REQ_FINISH, 4'd0, '0, 1'b1, '0));
		issue(make_request(REQ_FINISH, 4'd0, '0, 1'b0, '0));
		// freed slot is the lowest free one again
		issue(make_request(REQ_ADMIT, 4'd9, 22'h155555, 1'b0, '0));
		// pop everything in level order, the last one finds all queues empty
		repeat (9) issue(make_request(REQ_SCHEDULE, '0, 22'h2aaaaa, 1'b0, '0));

		// random part, one quantum setting per phase; odd phases starve the scheduler
		// so the queues and the table run full
		for (int p = 0; p < NUM_PHASES; p++) begin
			drain();
			case (p)
			0: begin
				q_one   = '0;
				q_two   = '0;
				q_three = '0;
			end
			1: begin
				q_one   = '1;
				q_two   = '1;
				q_three = '1;
			end
			2: begin
				q_one   = 24'd100;
				q_two   = 24'd2000;
				q_three = 24'd30000;
			end
			3: begin
				q_one   = QUANTUM_W'($urandom);
				q_two   = QUANTUM_W'($urandom);
				q_three = QUANTUM_W'($urandom);
			end
			4: begin
				q_one   = '1;
				q_two   = '0;
				q_three = 24'd1;
			end
			default: begin
				q_one   = QUANTUM_ONE_RST;
				q_two   = QUANTUM_TWO_RST;
				q_three = QUANTUM_THREE_RST;
			end
			endcase
			load_quanta(q_one, q_two, q_three);

			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// every field starts fully random, then the kind is chosen
				r = make_request(REQ_ADMIT, SLOT_PORT_W'($urandom), PID_WIDTH'($urandom),
					1'($urandom), QUANTUM_W'($urandom));
				roll = $urandom_range(99);
				if (roll < 4) begin
					r.req_type = REQ_UNKNOWN;
				end else if (roll < ((p % 2) ? 10 : 38)) begin
					r.req_type = REQ_SCHEDULE;
				end else if (roll >= 68) begin
					r.req_type = REQ_FINISH;
					pick = book.pick_busy_slot(busy_n);
					// most reports name a live process, the rest hit random slots
					if (pick >= 0 && $urandom_range(9) != 0) begin
						r.slot = SLOT_PORT_W'(pick);
						// completions grow with table occupancy to keep slots turning over
						r.completed = ($urandom_range(99) < busy_n * 3);
						// bursts cluster around the quantum of the slot's level
						q_near = book.quantum[book.slot_level[pick]];
						case ($urandom_range(7))
						0: r.last_burst = q_near - 1'b1;
						1: r.last_burst = q_near;
						2: r.last_burst = q_near + 1'b1;
						3: r.last_burst = '0;
						4: r.last_burst = '1;
						5: r.last_burst = QUANTUM_W'($urandom_range(q_near));
						default: ;
						endcase
					end
				end
				issue(r);
			end
		end

		// all requests taken: wait for the last results and any strays
		drain();
		if (book.failures == 0 && book.owed() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
